// ===== sv/base64_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared concurrent check macros; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("b64d: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("b64d: check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("b64d: check failed");

`else

`define B64D_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond)
`define B64D_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define B64D_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Item types, the decode job passed from front to back, and symbol lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_output;
  } out_item_t;

  // One decoded character's worth of results: up to three bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            present;
    logic            eot;
  } b64d_job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sym_t;

  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;

  // Map a character to its 6-bit symbol value; anything else is zero.
  function automatic b64d_sym_t symbol_decode(input logic [7:0] ch);
    logic [7:0] diff;
    b64d_sym_t  res;
    diff = 8'h00;
    res  = '0;
    if (ch >= CHR_UPPER_A && ch <= CHR_UPPER_Z) begin
      diff      = ch - CHR_UPPER_A;
      res.valid = 1'b1;
    end else if (ch >= CHR_LOWER_A && ch <= CHR_LOWER_Z) begin
      diff      = ch - CHR_LOWER_A + 8'd26;
      res.valid = 1'b1;
    end else if (ch >= CHR_DIGIT_0 && ch <= CHR_DIGIT_9) begin
      diff      = ch - CHR_DIGIT_0 + 8'd52;
      res.valid = 1'b1;
    end else if (ch == CHR_PLUS) begin
      diff      = 8'd62;
      res.valid = 1'b1;
    end else if (ch == CHR_SLASH) begin
      diff      = 8'd63;
      res.valid = 1'b1;
    end
    res.value = diff[5:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_front.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder front end
// Classifies each character, tracks the group, and builds a result job.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept_i,
  input  b64d_pkg::in_item_t  item_i,
  output logic                push_o,
  output b64d_pkg::b64d_job_t job_o
);
  import b64d_pkg::*;

  logic [5:0] sym0_r, sym1_r, sym2_r;
  logic [5:0] sym0_nxt, sym1_nxt, sym2_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       stopped_r, stopped_nxt;
  logic       begun_r, begun_nxt;

  b64d_sym_t       sym;
  logic            skip;
  logic [2:0][7:0] bytes;
  logic [1:0]      n_bytes;
  logic            eot;

  assign sym = symbol_decode(item_i.char_code);
  assign eot = item_i.end_of_text;

  always_comb begin
    sym0_nxt    = sym0_r;
    sym1_nxt    = sym1_r;
    sym2_nxt    = sym2_r;
    pos_nxt     = pos_r;
    stopped_nxt = stopped_r;
    begun_nxt   = begun_r;
    bytes       = '0;
    n_bytes     = 2'd0;
    skip        = begun_r && (pos_r == 2'd0) &&
                  (item_i.char_code == CHR_CR || item_i.char_code == CHR_LF);

    if (!stopped_r) begin
      if (!skip) begin
        case (pos_r)
          2'd0: begin
            sym0_nxt = sym.value;
            pos_nxt  = 2'd1;
          end
          2'd1: begin
            if (!sym.valid) begin
              bytes[0]    = {sym0_r, 2'b00};
              n_bytes     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              sym1_nxt = sym.value;
              pos_nxt  = 2'd2;
            end
          end
          2'd2: begin
            if (!sym.valid) begin
              bytes[0]    = {sym0_r, sym1_r[5:4]};
              n_bytes     = 2'd1;
              stopped_nxt = 1'b1;
            end else begin
              sym2_nxt = sym.value;
              pos_nxt  = 2'd3;
            end
          end
          default: begin
            bytes[0] = {sym0_r, sym1_r[5:4]};
            bytes[1] = {sym1_r[3:0], sym2_r[5:2]};
            if (!sym.valid) begin
              n_bytes     = 2'd2;
              stopped_nxt = 1'b1;
            end else begin
              bytes[2] = {sym2_r[1:0], sym.value};
              n_bytes  = 2'd3;
              pos_nxt  = 2'd0;
            end
          end
        endcase
      end
      begun_nxt = 1'b1;

      // A group cut short by the end of text flushes as if the next symbol
      // were invalid. No byte was produced above in any of these cases.
      if (eot && !stopped_nxt) begin
        case (pos_nxt)
          2'd1: begin
            bytes[0] = {sym0_nxt, 2'b00};
            n_bytes  = 2'd1;
          end
          2'd2: begin
            bytes[0] = {sym0_nxt, sym1_nxt[5:4]};
            n_bytes  = 2'd1;
          end
          2'd3: begin
            bytes[0] = {sym0_nxt, sym1_nxt[5:4]};
            bytes[1] = {sym1_nxt[3:0], sym2_nxt[5:2]};
            n_bytes  = 2'd2;
          end
          default: begin
            n_bytes = n_bytes;
          end
        endcase
      end
    end

    if (eot) begin
      sym0_nxt    = 6'd0;
      sym1_nxt    = 6'd0;
      sym2_nxt    = 6'd0;
      pos_nxt     = 2'd0;
      stopped_nxt = 1'b0;
      begun_nxt   = 1'b0;
    end
  end

  always_comb begin
    job_o.bytes    = bytes;
    job_o.eot      = eot;
    job_o.present  = (n_bytes != 2'd0);
    job_o.last_idx = (n_bytes == 2'd0) ? 2'd0 : n_bytes - 2'd1;
    push_o         = accept_i && ((n_bytes != 2'd0) || eot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym0_r    <= 6'd0;
      sym1_r    <= 6'd0;
      sym2_r    <= 6'd0;
      pos_r     <= 2'd0;
      stopped_r <= 1'b0;
      begun_r   <= 1'b0;
    end else if (accept_i) begin
      sym0_r    <= sym0_nxt;
      sym1_r    <= sym1_nxt;
      sym2_r    <= sym2_nxt;
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
      begun_r   <= begun_nxt;
    end
  end

  `B64D_ASSERT_NEXT(a_front_eot_clears, clk, rst_n, accept_i && eot, (pos_r == 2'd0) && !stopped_r && !begun_r)
  `B64D_ASSERT_IMPL(a_front_eot_pushes, clk, rst_n, accept_i && eot, push_o)

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder job queue
// Small first-in first-out store of jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  b64d_pkg::b64d_job_t data_i,
  input  logic                pop_i,
  output b64d_pkg::b64d_job_t data_o,
  output logic                full_o,
  output logic                empty_o
);
  import b64d_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64d_job_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `B64D_ASSERT_ALWAYS(a_queue_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `B64D_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, push_i, !full_o)

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder back end
// Holds the current job and hands out its results one item per cycle while pop is high and a job is held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty_i,
  input  b64d_pkg::b64d_job_t q_data_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output b64d_pkg::out_item_t item_o
);
  import b64d_pkg::*;

  b64d_job_t  cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take, finish, load;
  logic [7:0] sel_byte;

  assign take    = cur_valid_r && pop_i;
  assign finish  = take && (idx_r == cur_r.last_idx);
  assign load    = !cur_valid_r || finish;
  assign q_pop_o = load && !q_empty_i;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_nxt       = q_data_i;
      cur_valid_nxt = !q_empty_i;
      idx_nxt       = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = cur_r.bytes[0];
      2'd1:    sel_byte = cur_r.bytes[1];
      2'd2:    sel_byte = cur_r.bytes[2];
      default: sel_byte = 8'h00;
    endcase
  end

  assign empty_o              = !cur_valid_r;
  assign item_o.data_byte     = sel_byte;
  assign item_o.byte_present  = cur_r.present;
  assign item_o.end_of_output = cur_r.eot && (idx_r == cur_r.last_idx);

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  `B64D_ASSERT_IMPL(a_back_idx_bound, clk, rst_n, cur_valid_r, idx_r <= cur_r.last_idx)
  `B64D_ASSERT_IMPL(a_back_empty_job, clk, rst_n, cur_valid_r && !cur_r.present, cur_r.eot && (cur_r.last_idx == 2'd0))

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a Base64 character stream into bytes, one character per clock while full is low.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake     Payload
//   input     push / full   in_item  (char_code, end_of_text)
//   result    pop / empty   out_item (data_byte, byte_present, end_of_output)
//
// The front end takes one character per clock whenever full is low and
// turns it into a job of one to three result items, or into no job. The
// back end drains jobs at one result item per clock while pop is high,
// so the items of one character leave one after another; the result port
// sets the sustained rate. An item reaches the result ports once its job
// has been written into the queue and then loaded into the back end's
// register. Reset is synchronous. The job queue lets the front keep
// accepting while the result side stalls, until the queue fills.
//
// Decoding follows the usual Base64 alphabet. A group of four symbols gives
// three bytes. CR and LF are skipped only between groups and never as the
// first character of a string. An invalid or missing symbol in the second
// or third place yields one byte, in the fourth place two bytes, and the
// rest of the string is then ignored. The end of a string always produces
// an item marked with end_of_output; if no byte is due, that item carries
// byte_present low and a zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  b64d_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output b64d_pkg::out_item_t out_item
);
  import b64d_pkg::*;

  // Jobs travel from the front end through the queue to the back end.
  logic      in_accept;
  logic      job_push;
  b64d_job_t job_in;
  b64d_job_t job_out;
  logic      job_pop;
  logic      q_full;
  logic      q_empty;

  // A character is taken whenever the queue has room for its job, even if
  // it turns out to produce no job at all.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (in_accept),
    .item_i   (in_item),
    .push_o   (job_push),
    .job_o    (job_in)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back end keeps the job in flight in its own register, so the queue
  // entry is released as soon as the job is loaded.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .q_data_i  (job_out),
    .q_pop_o   (job_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Feeds encoded text one character at a time and checks every decoded byte,
// the byte-present flag and the end-of-output marker against a behavioral
// decoder model kept alongside the stimulus.
// ----------------------------------------------------------------------------

module tb_top;
  import b64d_pkg::*;

  // Clock, reset and the two queue-style channels of the decoder.
  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  base64_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // The Base64 alphabet in symbol order; a symbol's value is its index here.
  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Decoder model state: the symbols of the group in progress, how many of
  // them have been gathered, whether decoding has stopped for this string and
  // whether any character of the string has been taken yet.
  logic [5:0] grp_sym [3];
  logic [1:0] grp_pos;
  bit         halted;
  bit         text_begun;

  // Decoded result items that the block still owes us, oldest first.
  out_item_t  decoded_queue [$];

  int unsigned error_count = 0;
  int unsigned chars_sent  = 0;

  // Percent of cycles in which each side sits idle, and a receiver hold-off
  // that the receiver process counts down on its own.
  int unsigned tx_idle_pct  = 10;
  int unsigned rx_idle_pct  = 10;
  int unsigned rx_hold_left = 0;

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block stops moving.
  initial begin
    #1_200_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Look a character up in the alphabet. Characters outside it decode as zero.
  function automatic bit symbol_of(input logic [7:0] ch, output logic [5:0] val);
    val = '0;
    for (int i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == ch) begin
        val = i[5:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void clear_decoder();
    grp_sym[0] = '0;
    grp_sym[1] = '0;
    grp_sym[2] = '0;
    grp_pos    = 2'd0;
    halted     = 1'b0;
    text_begun = 1'b0;
  endfunction

  // Advance the model by one accepted character and queue the result items
  // it gives rise to. A group contributes bytes most significant bits first:
  // the first byte is symbol 0 and the top two bits of symbol 1, the second
  // is the low nibble of symbol 1 and the top four bits of symbol 2, the
  // third is the low two bits of symbol 2 followed by symbol 3.
  function automatic void decode_char(input in_item_t it);
    logic [7:0] bytes [3];
    int         n;
    logic [5:0] v;
    bit         ok;
    bit         line_break;
    out_item_t  r;
    n  = 0;
    ok = symbol_of(it.char_code, v);
    line_break = (it.char_code == CHR_CR) || (it.char_code == CHR_LF);

    if (!halted) begin
      // Line breaks are dropped only between groups, and never as the very
      // first character of a string.
      if (!(text_begun && grp_pos == 2'd0 && line_break)) begin
        case (grp_pos)
          2'd0: begin
            // The first symbol of a group is taken whatever it is.
            grp_sym[0] = v;
            grp_pos    = 2'd1;
          end
          2'd1: begin
            if (!ok) begin
              bytes[n] = {grp_sym[0], 2'b00};
              n++;
              halted = 1'b1;
            end else begin
              grp_sym[1] = v;
              grp_pos    = 2'd2;
            end
          end
          2'd2: begin
            if (!ok) begin
              bytes[n] = {grp_sym[0], grp_sym[1][5:4]};
              n++;
              halted = 1'b1;
            end else begin
              grp_sym[2] = v;
              grp_pos    = 2'd3;
            end
          end
          default: begin
            // The fourth place always yields the first two bytes; the third
            // only comes with a valid symbol.
            bytes[n] = {grp_sym[0], grp_sym[1][5:4]};
            n++;
            bytes[n] = {grp_sym[1][3:0], grp_sym[2][5:2]};
            n++;
            if (!ok) begin
              halted = 1'b1;
            end else begin
              bytes[n] = {grp_sym[2][1:0], v};
              n++;
              grp_pos = 2'd0;
            end
          end
        endcase
      end
      text_begun = 1'b1;

      // A group cut short by the end of the string behaves as if the next
      // symbol were missing.
      if (it.end_of_text && !halted) begin
        case (grp_pos)
          2'd1: begin
            bytes[n] = {grp_sym[0], 2'b00};
            n++;
          end
          2'd2: begin
            bytes[n] = {grp_sym[0], grp_sym[1][5:4]};
            n++;
          end
          2'd3: begin
            bytes[n] = {grp_sym[0], grp_sym[1][5:4]};
            n++;
            bytes[n] = {grp_sym[1][3:0], grp_sym[2][5:2]};
            n++;
          end
          default: begin
          end
        endcase
      end
    end

    for (int k = 0; k < n; k++) begin
      r.data_byte     = bytes[k];
      r.byte_present  = 1'b1;
      r.end_of_output = it.end_of_text && (k == n - 1);
      decoded_queue.push_back(r);
    end

    // The end of a string always produces a marked item, an empty one if no
    // byte is due, and the decoder starts over.
    if (it.end_of_text) begin
      if (n == 0) begin
        r.data_byte     = 8'h00;
        r.byte_present  = 1'b0;
        r.end_of_output = 1'b1;
        decoded_queue.push_back(r);
      end
      clear_decoder();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pops at random, honors a hold-off, checks every item taken.
  // --------------------------------------------------------------------------

  task automatic check_decoded(input out_item_t got);
    out_item_t want;
    if (decoded_queue.size() == 0) begin
      $error("unexpected result item: data_byte %02h byte_present %0b end_of_output %0b",
             got.data_byte, got.byte_present, got.end_of_output);
      error_count++;
      return;
    end
    want = decoded_queue.pop_front();
    if (got.data_byte !== want.data_byte) begin
      $error("data_byte: expected %02h, actual %02h", want.data_byte, got.data_byte);
      error_count++;
    end
    if (got.byte_present !== want.byte_present) begin
      $error("byte_present: expected %0b, actual %0b", want.byte_present, got.byte_present);
      error_count++;
    end
    if (got.end_of_output !== want.end_of_output) begin
      $error("end_of_output: expected %0b, actual %0b",
             want.end_of_output, got.end_of_output);
      error_count++;
    end
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        check_decoded(out_item);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one character, possibly after a few idle cycles, and hold it until
  // the block takes it. Push is left high on return so that a following item
  // can go out back to back; whoever stops sending lowers it.
  task automatic send_char(input logic [7:0] ch, input logic eot);
    in_item_t it;
    it.char_code   = ch;
    it.end_of_text = eot;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    decode_char(it);
    chars_sent++;
  endtask

  // Send a whole string; its last character carries the end flag.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] random_symbol();
    return b64_alphabet[$urandom_range(0, 63)];
  endfunction

  // A mostly well-formed encoded string: up to max_groups full groups with
  // line breaks between some of them, a short tail, and now and then a
  // leading or trailing line break or one character replaced by a random
  // byte so that decoding stops partway.
  task automatic send_random_text(input int unsigned max_groups);
    logic [7:0]  txt [$];
    int unsigned groups;
    int unsigned tail;
    int unsigned spot;
    groups = $urandom_range(0, max_groups);
    tail   = $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      txt.push_back($urandom_range(0, 1) ? CHR_CR : CHR_LF);
    end
    for (int g = 0; g < groups; g++) begin
      if (g > 0 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       txt.push_back(CHR_CR);
          1:       txt.push_back(CHR_LF);
          default: begin
            txt.push_back(CHR_CR);
            txt.push_back(CHR_LF);
          end
        endcase
      end
      repeat (4) txt.push_back(random_symbol());
    end
    repeat (tail) txt.push_back(random_symbol());
    if (txt.size() == 0) begin
      txt.push_back(random_symbol());
    end
    if ($urandom_range(0, 4) == 0) begin
      spot      = $urandom_range(0, txt.size() - 1);
      txt[spot] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 5) == 0) begin
      txt.push_back(CHR_LF);
    end
    foreach (txt[i]) begin
      send_char(txt[i], i == txt.size() - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked strings for the corners of the alphabet and the line-break
  // and stopping rules.
  task automatic test_directed();
    // Alphabet extremes in two groups with CR LF between them; the string
    // ends on a line break after a complete group, so the final item has no
    // byte.
    send_text("AZaz\015\n09+/\n");
    // A leading line feed counts as the first symbol; the string then ends
    // with three symbols gathered.
    send_text("\nQQ");
    // A carriage return inside a group stops decoding; what follows is
    // ignored up to the end of the string, which ends on an ignored byte.
    send_char("A", 1'b0);
    send_char(CHR_CR, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    // An invalid fourth symbol gives two bytes and the string ends on it.
    send_char("Q", 1'b0);
    send_char("U", 1'b0);
    send_char("J", 1'b0);
    send_char(8'h80, 1'b1);
    // A one-character string.
    send_text("A");
  endtask

  task automatic test_random_text(input int unsigned count);
    int unsigned stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      send_random_text(6);
    end
  endtask

  // Random bytes over the whole range with string ends at random places;
  // the last one always closes its string.
  task automatic test_noise(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_char(8'($urandom_range(0, 255)), (i == count - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  // The result side holds off for a long stretch while the sender keeps
  // offering characters, so the job queue fills and full must stall input.
  task automatic test_receiver_holdoff(input int unsigned count);
    int unsigned stop_at;
    tx_idle_pct  = 0;
    rx_hold_left = 200;
    stop_at      = chars_sent + count;
    while (chars_sent < stop_at) begin
      send_random_text(4);
    end
    tx_idle_pct = 10;
  endtask

  // Both sides at full rate for a long stretch.
  task automatic test_full_rate(input int unsigned count);
    int unsigned stop_at;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stop_at     = chars_sent + count;
    while (chars_sent < stop_at) begin
      send_random_text(5);
    end
    tx_idle_pct = 10;
    rx_idle_pct = 10;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;
    clear_decoder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_text(250);
    test_noise(70);
    test_receiver_holdoff(60);
    test_full_rate(80);

    // Stop sending, let every owed item arrive, then watch a little longer
    // for stray items.
    push <= 1'b0;
    while (decoded_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
